>>> rtl/pso_pkg.sv
// Shared types and codes for the particle swarm update block.
package pso_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_SQ,
    ST_FIT,
    ST_BEST,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_MOVE
  } state_e;

  localparam logic CMD_INIT   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam logic [1:0] REG_INERTIA   = 2'd0;
  localparam logic [1:0] REG_COGNITIVE = 2'd1;
  localparam logic [1:0] REG_SOCIAL    = 2'd2;

  localparam logic [15:0] INERTIA_RST   = 16'd11944;
  localparam logic [15:0] COGNITIVE_RST = 16'd24412;
  localparam logic [15:0] SOCIAL_RST    = 16'd24412;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic [31:0]        bv;
  } particle_t;

endpackage

>>> rtl/pso_particle_update.sv
// Particle swarm step on the Rastrigin function, particle state in one RAM.
//
//   channel   handshake                 payload
//   command   start / busy              command_i, particle_index_i, init_*, rand_*
//   result    done_o strobe, 1 cycle    out_index_o, new_pos_*, fitness_now_o, ...
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An update runs from accept through index fold by reciprocal multiply with RAM
// read, data capture, square, score, compare, two multiplier ranks, accumulate
// and write-back; an init skips ranks and accumulate. done_o follows write-back.
// Reset loads the default weights, zeroes the global best position and sets its
// value to all ones; the RAM is not cleared. Results cannot be stalled; a
// configuration word waits while busy or start is high.
module pso_particle_update #(
  parameter int PARTICLES      = 1024,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [9:0]         particle_index_i,
  input  logic signed [23:0] init_pos_x_i,
  input  logic signed [23:0] init_pos_y_i,
  input  logic signed [23:0] init_vel_x_i,
  input  logic signed [23:0] init_vel_y_i,
  input  logic [15:0]        rand_cog_x_i,
  input  logic [15:0]        rand_soc_x_i,
  input  logic [15:0]        rand_cog_y_i,
  input  logic [15:0]        rand_soc_y_i,
  output logic               done_o,
  output logic [9:0]         out_index_o,
  output logic signed [23:0] new_pos_x_o,
  output logic signed [23:0] new_pos_y_o,
  output logic [31:0]        fitness_now_o,
  output logic [31:0]        personal_best_value_o,
  output logic signed [23:0] swarm_best_x_o,
  output logic signed [23:0] swarm_best_y_o,
  output logic [31:0]        swarm_best_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int AW = $clog2(PARTICLES);
  localparam logic [16:0] PartW = 17'(PARTICLES);
  localparam logic [19:0] RecipM = 20'((1 << 20) / PARTICLES);

  function automatic logic signed [23:0] sat24(logic signed [59:0] v);
    if (v > 60'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -60'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  pso_pkg::state_e state_q, state_d;

  logic               cmd_q;
  logic [9:0]         idx_q;
  logic [9:0]         quo_q;
  logic [16:0]        red_q;
  logic signed [23:0] ipx_q, ipy_q, ivx_q, ivy_q;
  logic [15:0]        rcx_q, rsx_q, rcy_q, rsy_q;
  logic [15:0]        w_q, c1_q, c2_q;

  logic signed [23:0] px_q, py_q, vx_q, vy_q, bx_q, by_q;
  logic [31:0]        bv_q;
  logic signed [23:0] gbx_q, gby_q;
  logic [31:0]        gbv_q;
  logic signed [47:0] sqx_q, sqy_q;
  logic [31:0]        fit_q;
  logic signed [24:0] dpx_q, dpy_q, dgx_q, dgy_q;
  logic signed [40:0] wvx_q, wvy_q;
  logic [31:0]        crx_q, srx_q, cry_q, sry_q;
  logic signed [57:0] prx_q, psx_q, pry_q, psy_q;
  logic signed [23:0] vnx_q, vny_q;

  logic                 ram_we, ram_re;
  pso_pkg::particle_t   ram_rdata, ram_wdata;
  logic signed [17:0]   cos_x, cos_y;

  logic               accept;
  logic [16:0]        rem_raw;
  logic [16:0]        slot;
  logic [17:0]        ux, uy;
  logic [33:0]        fsum;
  logic               pb_win;
  logic [31:0]        nbv;
  logic signed [23:0] nbx, nby;
  logic signed [59:0] accx, accy;
  logic signed [23:0] npx, npy;

  assign accept      = start && !busy;
  assign cfg_ready_o = !busy && !start;

  pso_ram #(
    .WIDTH($bits(pso_pkg::particle_t)),
    .DEPTH(PARTICLES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(red_q[AW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(slot[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  pso_cos_rom #(
    .COS_TABLE_BITS(COS_TABLE_BITS)
  ) u_cos (
    .clk_i   (clk_i),
    .addr_x_i(px_q[15:16-COS_TABLE_BITS]),
    .addr_y_i(py_q[15:16-COS_TABLE_BITS]),
    .cos_x_o (cos_x),
    .cos_y_o (cos_y)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pso_pkg::ST_IDLE: if (start) state_d = pso_pkg::ST_MOD;
      pso_pkg::ST_MOD:  state_d = pso_pkg::ST_READ;
      pso_pkg::ST_READ: state_d = pso_pkg::ST_SQ;
      pso_pkg::ST_SQ:   state_d = pso_pkg::ST_FIT;
      pso_pkg::ST_FIT:  state_d = pso_pkg::ST_BEST;
      pso_pkg::ST_BEST: begin
        state_d = (cmd_q == pso_pkg::CMD_INIT) ? pso_pkg::ST_MOVE : pso_pkg::ST_MUL1;
      end
      pso_pkg::ST_MUL1: state_d = pso_pkg::ST_MUL2;
      pso_pkg::ST_MUL2: state_d = pso_pkg::ST_ACC;
      pso_pkg::ST_ACC:  state_d = pso_pkg::ST_MOVE;
      pso_pkg::ST_MOVE: state_d = pso_pkg::ST_IDLE;
      default:          state_d = pso_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state_q != pso_pkg::ST_IDLE);
    ram_re = (state_q == pso_pkg::ST_MOD);
    ram_we = (state_q == pso_pkg::ST_MOVE);
  end

  always_comb begin
    rem_raw = 17'(27'(idx_q) - 27'(quo_q) * 27'(PARTICLES));
    slot    = (rem_raw >= PartW) ? rem_raw - PartW : rem_raw;

    ux   = 18'(19'sd65536 - 19'(cos_x));
    uy   = 18'(19'sd65536 - 19'(cos_y));
    fsum = 34'(sqx_q[47:16]) + 34'(sqy_q[47:16]) + 34'(ux) * 34'd10 + 34'(uy) * 34'd10;

    pb_win = fit_q < bv_q;
    if (cmd_q == pso_pkg::CMD_INIT || pb_win) begin
      nbv = fit_q;
      nbx = px_q;
      nby = py_q;
    end else begin
      nbv = bv_q;
      nbx = bx_q;
      nby = by_q;
    end

    accx = (60'(wvx_q) <<< 16) + 60'(prx_q) + 60'(psx_q);
    accy = (60'(wvy_q) <<< 16) + 60'(pry_q) + 60'(psy_q);

    if (cmd_q == pso_pkg::CMD_INIT) begin
      npx = px_q;
      npy = py_q;
    end else begin
      npx = sat24(60'(px_q) + 60'(vnx_q));
      npy = sat24(60'(py_q) + 60'(vny_q));
    end

    ram_wdata = '{px: npx, py: npy, vx: vnx_q, vy: vny_q, bx: bx_q, by: by_q, bv: bv_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pso_pkg::ST_IDLE;
      done_o  <= 1'b0;
      w_q     <= pso_pkg::INERTIA_RST;
      c1_q    <= pso_pkg::COGNITIVE_RST;
      c2_q    <= pso_pkg::SOCIAL_RST;
      gbx_q   <= '0;
      gby_q   <= '0;
      gbv_q   <= '1;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == pso_pkg::ST_MOVE);
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          pso_pkg::REG_INERTIA:   w_q  <= cfg_data_i;
          pso_pkg::REG_COGNITIVE: c1_q <= cfg_data_i;
          pso_pkg::REG_SOCIAL:    c2_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == pso_pkg::ST_BEST && cmd_q == pso_pkg::CMD_UPDATE && nbv < gbv_q) begin
        gbv_q <= nbv;
        gbx_q <= nbx;
        gby_q <= nby;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      idx_q <= particle_index_i;
      quo_q <= 10'((30'(particle_index_i) * 30'(RecipM)) >> 20);
      ipx_q <= init_pos_x_i;
      ipy_q <= init_pos_y_i;
      ivx_q <= init_vel_x_i;
      ivy_q <= init_vel_y_i;
      rcx_q <= rand_cog_x_i;
      rsx_q <= rand_soc_x_i;
      rcy_q <= rand_cog_y_i;
      rsy_q <= rand_soc_y_i;
    end
    unique case (state_q)
      pso_pkg::ST_MOD: begin
        red_q <= slot;
      end
      pso_pkg::ST_READ: begin
        if (cmd_q == pso_pkg::CMD_INIT) begin
          px_q <= ipx_q;
          py_q <= ipy_q;
          vx_q <= ivx_q;
          vy_q <= ivy_q;
        end else begin
          px_q <= ram_rdata.px;
          py_q <= ram_rdata.py;
          vx_q <= ram_rdata.vx;
          vy_q <= ram_rdata.vy;
          bx_q <= ram_rdata.bx;
          by_q <= ram_rdata.by;
          bv_q <= ram_rdata.bv;
        end
      end
      pso_pkg::ST_SQ: begin
        sqx_q <= px_q * px_q;
        sqy_q <= py_q * py_q;
      end
      pso_pkg::ST_FIT: begin
        fit_q <= (fsum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : fsum[31:0];
      end
      pso_pkg::ST_BEST: begin
        bv_q  <= nbv;
        bx_q  <= nbx;
        by_q  <= nby;
        vnx_q <= vx_q;
        vny_q <= vy_q;
      end
      pso_pkg::ST_MUL1: begin
        dpx_q <= 25'(bx_q) - 25'(px_q);
        dpy_q <= 25'(by_q) - 25'(py_q);
        dgx_q <= 25'(gbx_q) - 25'(px_q);
        dgy_q <= 25'(gby_q) - 25'(py_q);
        wvx_q <= $signed({1'b0, w_q}) * vx_q;
        wvy_q <= $signed({1'b0, w_q}) * vy_q;
        crx_q <= c1_q * rcx_q;
        srx_q <= c2_q * rsx_q;
        cry_q <= c1_q * rcy_q;
        sry_q <= c2_q * rsy_q;
      end
      pso_pkg::ST_MUL2: begin
        prx_q <= $signed({1'b0, crx_q}) * dpx_q;
        psx_q <= $signed({1'b0, srx_q}) * dgx_q;
        pry_q <= $signed({1'b0, cry_q}) * dpy_q;
        psy_q <= $signed({1'b0, sry_q}) * dgy_q;
      end
      pso_pkg::ST_ACC: begin
        vnx_q <= sat24(accx >>> 30);
        vny_q <= sat24(accy >>> 30);
      end
      pso_pkg::ST_MOVE: begin
        out_index_o           <= idx_q;
        new_pos_x_o           <= npx;
        new_pos_y_o           <= npy;
        fitness_now_o         <= fit_q;
        personal_best_value_o <= bv_q;
        swarm_best_x_o        <= gbx_q;
        swarm_best_y_o        <= gby_q;
        swarm_best_value_o    <= gbv_q;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/pso_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/pso_cos_rom.sv
// Cosine table, built at elaboration, with two registered read ports.
module pso_cos_rom #(
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                      clk_i,
  input  logic [COS_TABLE_BITS-1:0] addr_x_i,
  input  logic [COS_TABLE_BITS-1:0] addr_y_i,
  output logic signed [17:0]        cos_x_o,
  output logic signed [17:0]        cos_y_o
);

  localparam int Entries = 2 ** COS_TABLE_BITS;
  localparam longint unsigned QOne = 64'd1073741824;

  typedef logic signed [17:0] tab_t [Entries];

  function automatic longint unsigned sub0(longint unsigned a, longint unsigned b);
    return (b > a) ? 64'd0 : a - b;
  endfunction

  function automatic longint unsigned cos_q30(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    x  = r * 64'd102944;
    x2 = (x * x) >> 30;
    t  = QOne;
    t  = sub0(QOne, ((x2 * t) >> 30) / 64'd132);
    t  = sub0(QOne, ((x2 * t) >> 30) / 64'd90);
    t  = sub0(QOne, ((x2 * t) >> 30) / 64'd56);
    t  = sub0(QOne, ((x2 * t) >> 30) / 64'd30);
    t  = sub0(QOne, ((x2 * t) >> 30) / 64'd12);
    t  = sub0(QOne, ((x2 * t) >> 30) / 64'd2);
    return t;
  endfunction

  function automatic tab_t build_tab();
    tab_t            tab;
    longint unsigned p;
    longint unsigned q;
    longint unsigned r;
    longint unsigned c;
    longint unsigned m;
    for (int k = 0; k < Entries; k++) begin
      p = (longint'(k) << (16 - COS_TABLE_BITS)) & 64'hFFFF;
      q = p >> 14;
      r = p & 64'h3FFF;
      c = (q == 0 || q == 2) ? cos_q30(r) : cos_q30(64'd16384 - r);
      m = (c + 64'd8192) >> 14;
      tab[k] = (q == 1 || q == 2) ? -18'(m) : 18'(m);
    end
    return tab;
  endfunction

  localparam tab_t CosTab = build_tab();

  always_ff @(posedge clk_i) begin
    cos_x_o <= CosTab[addr_x_i];
    cos_y_o <= CosTab[addr_y_i];
  end

endmodule

>>> rtl/pso_checker.sv
// Port-level checks for the particle swarm update block, bound to the top level.
module pso_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] fitness_now_o,
  input logic [31:0] personal_best_value_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("busy not raised after accepted word");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $fell(busy))
    else $error("result word not at end of item");

  a_best_le_now: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> personal_best_value_o <= fitness_now_o)
    else $error("personal best above current fitness");

endmodule

bind pso_particle_update pso_checker u_pso_checker (.*);
